// ----- rtl/core/skt_pkg.sv -----
// shared types and constants for the three-axis scalar kalman smoother
package skt_pkg;

    // configuration register indexes
    typedef logic [2:0] cfg_index_t;
    localparam cfg_index_t REG_PROCESS_NOISE = 3'd0;
    localparam cfg_index_t REG_MEASURE_NOISE = 3'd1;
    localparam cfg_index_t REG_START_X       = 3'd2;
    localparam cfg_index_t REG_START_Y       = 3'd3;
    localparam cfg_index_t REG_START_Z       = 3'd4;

    // gain format, unsigned q1.16 with room for 1.0
    localparam int unsigned GAIN_W    = 17;
    localparam logic [16:0] GAIN_ONE  = 17'h10000;
    localparam int unsigned DIV_STEPS = GAIN_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    // update target select
    typedef logic [1:0] target_t;
    localparam target_t TGT_X = 2'd0;
    localparam target_t TGT_Y = 2'd1;
    localparam target_t TGT_Z = 2'd2;
    localparam target_t TGT_P = 2'd3;

    // command codes
    localparam logic CMD_FILTER  = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    typedef struct packed {
        logic               command;
        logic signed [15:0] sample_x;
        logic signed [15:0] sample_y;
        logic signed [15:0] sample_z;
    } item_t;

    typedef struct packed {
        logic signed [31:0] smooth_x;
        logic signed [31:0] smooth_y;
        logic signed [31:0] smooth_z;
        logic [16:0]        gain_used;
    } result_t;

    // controller to datapath commands
    typedef struct packed {
        logic    load_in;
        logic    restart;
        logic    predict;
        logic    den_init;
        logic    div_step;
        logic    diff;
        logic    mul;
        logic    acc;
        logic    load_out;
        target_t sel;
    } dp_cmd_t;

endpackage

// ----- rtl/core/skt_ctrl.sv -----
// sequencing state machine for the kalman smoother
module skt_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             item_command,
    output logic             item_ready,
    output logic             result_valid,
    input  logic             result_ready,
    output skt_pkg::dp_cmd_t cmd
);
    import skt_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PRED = 3'd1;
    localparam logic [2:0] S_DEN  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DIFF = 3'd4;
    localparam logic [2:0] S_MUL  = 3'd5;
    localparam logic [2:0] S_ACC  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    logic [2:0]           state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    target_t              sel_reg, sel_next;
    logic                 rvalid_reg, rvalid_next;
    logic                 take;

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = rvalid_reg;
    assign take         = item_valid && item_ready;

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        sel_next    = sel_reg;
        rvalid_next = rvalid_reg && !result_ready;
        cmd         = '0;
        cmd.sel     = sel_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    cmd.load_in = 1'b1;
                    if (item_command == CMD_RESTART)
                    begin
                        cmd.restart = 1'b1;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        state_next = S_PRED;
                    end
                end
            end
            S_PRED:
            begin
                cmd.predict = 1'b1;
                state_next  = S_DEN;
            end
            S_DEN:
            begin
                cmd.den_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    sel_next   = TGT_X;
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc  = 1'b1;
                sel_next = sel_reg + 1'b1;
                if (sel_reg == TGT_P)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_DIFF;
                end
            end
            S_OUT:
            begin
                if (!rvalid_reg || result_ready)
                begin
                    cmd.load_out = 1'b1;
                    rvalid_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            sel_reg    <= TGT_X;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            sel_reg    <= sel_next;
            rvalid_reg <= rvalid_next;
        end
    end

    // a new result never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!rvalid_reg || result_ready))
        else $error("result loaded over a pending transfer");

    // the divider counter stays inside its step count
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (cnt_reg <= DIV_LAST))
        else $error("divider step count overrun");

    // a filter transfer starts the prediction, a restart goes to output
    assert property (@(posedge clk) disable iff (!rst_n)
        take && (item_command == CMD_FILTER) |=> (state_reg == S_PRED))
        else $error("filter transfer did not start prediction");

    assert property (@(posedge clk) disable iff (!rst_n)
        take && (item_command == CMD_RESTART) |=> (state_reg == S_OUT))
        else $error("restart transfer did not go to output");

endmodule

// ----- rtl/core/skt_dp.sv -----
// datapath: state, gain divider, shared multiplier and output register
module skt_dp #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  skt_pkg::dp_cmd_t   cmd,
    input  skt_pkg::item_t     item,
    input  logic [31:0]        process_noise,
    input  logic [31:0]        measure_noise,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,
    input  logic signed [31:0] start_z,
    output skt_pkg::result_t   result
);
    import skt_pkg::*;

    localparam logic [31:0]        P_ONE = 32'(1) << FRAC_BITS;
    localparam logic signed [47:0] MAX48 = 48'sd2147483647;
    localparam logic signed [47:0] MIN48 = -48'sd2147483648;
    localparam logic signed [35:0] MAX36 = 36'sd2147483647;
    localparam logic signed [35:0] MIN36 = -36'sd2147483648;

    // sample scaled to the estimate format, saturated to 32 bits
    function automatic logic signed [31:0] to_meas(input logic signed [15:0] s);
        logic signed [47:0] w;
        w = 48'(s) <<< FRAC_BITS;
        if (w > MAX48)
            return 32'sh7FFF_FFFF;
        else if (w < MIN48)
            return 32'sh8000_0000;
        else
            return w[31:0];
    endfunction

    logic signed [31:0] est_x_reg, est_y_reg, est_z_reg;
    logic [31:0]        p_reg, pp_reg;
    logic signed [15:0] sx_reg, sy_reg, sz_reg;
    logic [32:0]        den_reg;
    logic [33:0]        rem_reg;
    logic [16:0]        num_reg, q_reg;
    logic               gain_zero_reg;
    logic signed [17:0] opa_reg;
    logic signed [33:0] opb_reg;
    logic signed [51:0] prod_reg;
    result_t            result_reg;

    logic [16:0]        gain;
    logic [32:0]        pred_sum;
    logic [32:0]        den_sum;
    logic [33:0]        trial;
    logic signed [31:0] x_sel, m_sel;
    logic signed [35:0] upd_sum;
    logic signed [31:0] upd_sat;

    assign gain   = gain_zero_reg ? '0 : q_reg;
    assign result = result_reg;

    // operand select for the axis being updated
    always_comb
    begin
        case (cmd.sel)
            TGT_X:
            begin
                x_sel = est_x_reg;
                m_sel = to_meas(sx_reg);
            end
            TGT_Y:
            begin
                x_sel = est_y_reg;
                m_sel = to_meas(sy_reg);
            end
            TGT_Z:
            begin
                x_sel = est_z_reg;
                m_sel = to_meas(sz_reg);
            end
            default:
            begin
                x_sel = est_x_reg;
                m_sel = '0;
            end
        endcase
    end

    // prediction, denominator and divider step
    assign pred_sum = {1'b0, p_reg} + {1'b0, process_noise};
    assign den_sum  = {1'b0, pp_reg} + {1'b0, measure_noise};
    assign trial    = {rem_reg[32:0], num_reg[16]};

    // estimate update with floor of the q16 product and saturation
    assign upd_sum = 36'(x_sel) + $signed(prod_reg[51:16]);
    always_comb
    begin
        if (upd_sum > MAX36)
            upd_sat = 32'sh7FFF_FFFF;
        else if (upd_sum < MIN36)
            upd_sat = 32'sh8000_0000;
        else
            upd_sat = upd_sum[31:0];
    end

    // filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_x_reg     <= '0;
            est_y_reg     <= '0;
            est_z_reg     <= '0;
            p_reg         <= P_ONE;
            gain_zero_reg <= 1'b1;
        end
        else
        begin
            if (cmd.restart)
            begin
                est_x_reg     <= start_x;
                est_y_reg     <= start_y;
                est_z_reg     <= start_z;
                p_reg         <= P_ONE;
                gain_zero_reg <= 1'b1;
            end
            if (cmd.den_init)
            begin
                gain_zero_reg <= (den_sum == '0);
            end
            if (cmd.acc)
            begin
                case (cmd.sel)
                    TGT_X:   est_x_reg <= upd_sat;
                    TGT_Y:   est_y_reg <= upd_sat;
                    TGT_Z:   est_z_reg <= upd_sat;
                    default: p_reg     <= prod_reg[47:16];
                endcase
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            sx_reg <= item.sample_x;
            sy_reg <= item.sample_y;
            sz_reg <= item.sample_z;
        end
        if (cmd.predict)
        begin
            pp_reg <= pred_sum[32] ? 32'hFFFF_FFFF : pred_sum[31:0];
        end
        if (cmd.den_init)
        begin
            den_reg <= den_sum;
            rem_reg <= {3'b000, pp_reg[31:1]};
            num_reg <= {pp_reg[0], 16'h0000};
            q_reg   <= '0;
        end
        if (cmd.div_step)
        begin
            num_reg <= {num_reg[15:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_reg <= trial - {1'b0, den_reg};
                q_reg   <= {q_reg[15:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                q_reg   <= {q_reg[15:0], 1'b0};
            end
        end
        if (cmd.diff)
        begin
            if (cmd.sel == TGT_P)
            begin
                opa_reg <= $signed({1'b0, GAIN_ONE - gain});
                opb_reg <= $signed({2'b00, pp_reg});
            end
            else
            begin
                opa_reg <= $signed({1'b0, gain});
                opb_reg <= 34'(m_sel) - 34'(x_sel);
            end
        end
        if (cmd.mul)
        begin
            prod_reg <= opa_reg * opb_reg;
        end
        if (cmd.load_out)
        begin
            result_reg.smooth_x  <= est_x_reg;
            result_reg.smooth_y  <= est_y_reg;
            result_reg.smooth_z  <= est_z_reg;
            result_reg.gain_used <= gain;
        end
    end

    // the divider remainder stays below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (rem_reg < {1'b0, den_reg}) || (den_reg == '0))
        else $error("divider remainder out of range");

    // the gain never exceeds one
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.diff |-> (gain <= GAIN_ONE))
        else $error("gain above one");

    // covariance never grows through the update
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc && (cmd.sel == TGT_P) |=> (p_reg <= $past(pp_reg)))
        else $error("covariance grew in update");

endmodule

// ----- rtl/core/scalar_kalman_three_axis.sv -----
// top level of the three-axis scalar kalman smoother with its register file
// a filter transfer passes through prediction, denominator, a 17-step restoring gain divider,
//   then difference, multiply and accumulate for x, y, z and covariance in turn on one
//   shared multiplier, and the output state, which waits while an earlier result is pending
// no new item is taken until the block has loaded its result and returned to idle
// a restart transfer loads the start values and goes straight to the output state
// reset: registers take their reset values, estimates 0, covariance 1.0, no result
module scalar_kalman_three_axis #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  skt_pkg::item_t      item,
    output logic                result_valid,
    input  logic                result_ready,
    output skt_pkg::result_t    result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  skt_pkg::cfg_index_t cfg_index,
    input  logic [31:0]         cfg_data
);
    import skt_pkg::*;

    logic [31:0]        q_reg, r_reg;
    logic signed [31:0] sx_reg, sy_reg, sz_reg;
    dp_cmd_t            cmd;

    assign cfg_ready = 1'b1;

    // configuration register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg  <= 32'd655;
            r_reg  <= 32'd65536;
            sx_reg <= '0;
            sy_reg <= '0;
            sz_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PROCESS_NOISE: q_reg  <= cfg_data;
                REG_MEASURE_NOISE: r_reg  <= cfg_data;
                REG_START_X:       sx_reg <= cfg_data;
                REG_START_Y:       sy_reg <= cfg_data;
                REG_START_Z:       sz_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // sequencer
    skt_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_command (item.command),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd)
    );

    // datapath
    skt_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .item          (item),
        .process_noise (q_reg),
        .measure_noise (r_reg),
        .start_x       (sx_reg),
        .start_y       (sy_reg),
        .start_z       (sz_reg),
        .result        (result)
    );

    // reported gain never exceeds 1.0 in unsigned q1.16
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.gain_used <= GAIN_ONE))
        else $error("reported gain above one");

    // a restart result carries zero gain and the start values
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.restart ##1 cmd.load_out |=> (result.gain_used == '0)
            && (result.smooth_x == $past(sx_reg, 2)))
        else $error("restart result mismatch");

    // no item is taken while the block is still working on one
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_in |=> !item_ready)
        else $error("item taken while busy");

endmodule
